### rtl/core/lirs_pkg.sv
// Package of the linear interpolation resampler: field widths, history depth
// and result limit shared by the interfaces and the core.
// No dependencies.
`default_nettype none

package lirs_pkg;

  // Default sample and phase fraction widths
  localparam int LIRS_SAMPLE_BITS = 16;
  localparam int LIRS_FRAC_BITS   = 16;

  // Width of the rate_step register (unsigned Q4.16)
  localparam int RATE_W = 20;

  // Sample history ring and its address width
  localparam int HIST_DEPTH = 32;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  // Most results one input transaction may cause
  localparam int MAX_RES = 8;
  localparam int CNT_W   = $clog2(MAX_RES);

endpackage

`default_nettype wire

### rtl/core/lirs_if.sv
// Valid/ready channel interfaces of the linear interpolation resampler:
// one for input samples, one for results.
// Depends on lirs_pkg for default widths.
`default_nettype none

interface lirs_in_if #(
  parameter int SAMPLE_BITS = lirs_pkg::LIRS_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          clip_end;

  modport source (output valid, output sample_in, output clip_end, input ready);
  modport sink   (input valid, input sample_in, input clip_end, output ready);
endinterface

interface lirs_out_if #(
  parameter int SAMPLE_BITS = lirs_pkg::LIRS_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          has_sample;
  logic                          end_of_clip;
  logic                          run_last;

  modport source (output valid, output sample_out, output has_sample,
                  output end_of_clip, output run_last, input ready);
  modport sink   (input valid, input sample_out, input has_sample,
                  input end_of_clip, input run_last, output ready);
endinterface

`default_nettype wire

### rtl/core/linear_interp_resampler_top.sv
// Linear interpolation resampler: history ring, phase sequencer and
// one shared subtract-multiply-add unit.
// Depends on lirs_pkg and the channel interfaces in lirs_if.sv.
//
//   channel   direction  handshake      payload
//   in_ch     sink       valid/ready    sample_in, clip_end
//   out_ch    source     valid/ready    sample_out, has_sample, end_of_clip, run_last
//   cfg_*     sink       cfg_we only    cfg_wdata (rate_step)
//
// Passthrough runs the idle and pass steps per input. An interpolating input is
// written and checked first, then each output sample takes the steps read left,
// read right, multiply, add; at most 8 outputs per input. The single-port history
// ring and the one multiplier set this sequence.
// Synchronous active-low reset; the history ring is not cleared, only written
// entries of the running clip are ever read.
// A stalled result holds the sequencer in its emit, pass or check step; no input is taken
// until the current one is finished.
`default_nettype none

module linear_interp_resampler_top #(
  parameter int SAMPLE_BITS = lirs_pkg::LIRS_SAMPLE_BITS,
  parameter int FRAC_BITS   = lirs_pkg::LIRS_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  lirs_in_if.sink                          in_ch,
  lirs_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [lirs_pkg::RATE_W-1:0] cfg_wdata
);
  import lirs_pkg::*;

  // Derived widths and constants
  localparam int S_W    = FRAC_BITS + 4;
  localparam int CMP_W  = (RATE_W > S_W) ? RATE_W : S_W;
  localparam int PH_W   = FRAC_BITS + 7;
  localparam int L_W    = PH_W - FRAC_BITS;
  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

  localparam logic [CMP_W-1:0] STEP_MIN   = CMP_W'(1) << (FRAC_BITS - 2);
  localparam logic [CMP_W-1:0] STEP_MAX   = (CMP_W'(1) << (FRAC_BITS + 4)) - CMP_W'(1);
  localparam logic [RATE_W-1:0] RATE_RST  = RATE_W'(CMP_W'(1) << FRAC_BITS);
  localparam logic [PH_W-1:0]  PH_ONE     = PH_W'(1) << FRAC_BITS;
  localparam logic [PH_W-1:0]  PH_BIAS    = PH_W'(HIST_DEPTH) << FRAC_BITS;
  localparam logic [PH_W-1:0]  PH_LIMIT   = PH_W'(HIST_DEPTH + 1) << FRAC_BITS;
  localparam logic [L_W-1:0]   L_HIST     = L_W'(HIST_DEPTH);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(MAX_RES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_CHECK,
    S_ADDR_A,
    S_ADDR_B,
    S_MUL,
    S_EMIT
  } state_t;

  // Control and datapath registers
  state_t                        state_r, state_nxt;
  logic [RATE_W-1:0]             rate_r;
  logic [S_W-1:0]                step_r, step_nxt;
  logic [PH_W-1:0]               phase_r, phase_nxt;
  logic [HIST_AW-1:0]            head_r, head_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic                          end_r, end_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_sample_r, prev_sample_nxt;
  logic signed [SAMPLE_BITS-1:0] a_r, a_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                          out_has_r, out_has_nxt;
  logic                          out_eoc_r, out_eoc_nxt;
  logic                          out_last_r, out_last_nxt;

  // History ring
  logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic [HIST_AW-1:0]            rd_addr;
  logic                          wr_en;

  // Combinational helpers
  logic                          in_acc;
  logic                          out_free;
  logic [CMP_W-1:0]              rate_ext;
  logic [S_W-1:0]                eff_step;
  logic [L_W-1:0]                l_cur;
  logic                          l_at_end;
  logic [HIST_AW-1:0]            a_addr;
  logic [HIST_AW-1:0]            b_addr;
  logic [PH_W-1:0]               phase_adv;
  logic                          more;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PROD_W-1:0]      prod_shr;
  logic signed [SAMPLE_BITS-1:0] interp_val;

  // An output may be formed when it is certain and its right neighbour exists
  function automatic logic can_emit(input logic [PH_W-1:0] ph,
                                    input logic [S_W-1:0]  st,
                                    input logic            clip_done,
                                    input logic            cnt_ok);
    logic [PH_W-1:0] sum;
    logic [L_W-1:0]  l;
    sum = ph + PH_W'(st);
    l   = ph[PH_W-1:FRAC_BITS];
    return (sum <= PH_LIMIT) && (clip_done || (l < L_HIST)) && cnt_ok;
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Clamp the configured ratio to the supported range; zero selects passthrough
  always_comb begin
    rate_ext = CMP_W'(rate_r);
    if (rate_ext == '0) begin
      eff_step = '0;
    end else if (rate_ext < STEP_MIN) begin
      eff_step = S_W'(STEP_MIN);
    end else if (rate_ext > STEP_MAX) begin
      eff_step = S_W'(STEP_MAX);
    end else begin
      eff_step = S_W'(rate_ext);
    end
  end

  // Neighbour addresses from the integer part of the phase
  assign l_cur    = phase_r[PH_W-1:FRAC_BITS];
  assign l_at_end = (l_cur >= L_HIST);
  assign a_addr   = head_r + phase_r[FRAC_BITS +: HIST_AW];
  assign b_addr   = l_at_end ? head_r : a_addr + HIST_AW'(1);
  assign rd_addr  = (state_r == S_ADDR_B) ? b_addr : a_addr;

  // Shared arithmetic: difference times fraction, then floor shift and add
  assign diff       = $signed({rd_data_r[SAMPLE_BITS-1], rd_data_r})
                    - $signed({a_r[SAMPLE_BITS-1], a_r});
  assign frac_s     = $signed({1'b0, phase_r[FRAC_BITS-1:0]});
  assign prod_shr   = prod_r >>> FRAC_BITS;
  assign interp_val = a_r + prod_shr[SAMPLE_BITS-1:0];

  // Look ahead to the next output of this transaction
  assign phase_adv = phase_r + PH_W'(step_r);
  assign more      = can_emit(phase_adv, step_r, end_r, cnt_r != CNT_LAST);

  assign wr_en = in_acc && (eff_step != '0);

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    phase_nxt       = phase_r;
    head_nxt        = head_r;
    have_prev_nxt   = have_prev_r;
    end_nxt         = end_r;
    cnt_nxt         = cnt_r;
    prev_sample_nxt = prev_sample_r;
    a_nxt           = a_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_sample_nxt  = out_sample_r;
    out_has_nxt     = out_has_r;
    out_eoc_nxt     = out_eoc_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          step_nxt        = eff_step;
          end_nxt         = in_ch.clip_end;
          prev_sample_nxt = in_ch.sample_in;
          cnt_nxt         = '0;
          if (eff_step == '0) begin
            have_prev_nxt = 1'b0;
            state_nxt     = S_PASS;
          end else begin
            phase_nxt     = have_prev_r ? phase_r - PH_ONE : PH_BIAS;
            head_nxt      = head_r + HIST_AW'(1);
            have_prev_nxt = !in_ch.clip_end;
            state_nxt     = S_CHECK;
          end
        end
      end

      // Send the sample unchanged
      S_PASS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = prev_sample_r;
          out_has_nxt    = 1'b1;
          out_eoc_nxt    = end_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // First output of the transaction, or the empty-close marker
      S_CHECK: begin
        if (can_emit(phase_r, step_r, end_r, 1'b1)) begin
          state_nxt = S_ADDR_A;
        end else if (!end_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = '0;
          out_has_nxt    = 1'b0;
          out_eoc_nxt    = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_ADDR_A: begin
        state_nxt = S_ADDR_B;
      end

      // Capture the left neighbour
      S_ADDR_B: begin
        a_nxt     = rd_data_r;
        state_nxt = S_MUL;
      end

      // Right neighbour is on the read port
      S_MUL: begin
        prod_nxt  = diff * frac_s;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = interp_val;
          out_has_nxt    = 1'b1;
          out_eoc_nxt    = end_r && !more;
          out_last_nxt   = !more;
          phase_nxt      = phase_adv;
          cnt_nxt        = cnt_r + CNT_W'(1);
          state_nxt      = more ? S_ADDR_A : S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= RATE_RST;
      have_prev_r <= 1'b0;
      phase_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      phase_r     <= phase_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        rate_r <= cfg_wdata;
      end
    end
    step_r        <= step_nxt;
    end_r         <= end_nxt;
    cnt_r         <= cnt_nxt;
    prev_sample_r <= prev_sample_nxt;
    a_r           <= a_nxt;
    prod_r        <= prod_nxt;
    out_sample_r  <= out_sample_nxt;
    out_has_r     <= out_has_nxt;
    out_eoc_r     <= out_eoc_nxt;
    out_last_r    <= out_last_nxt;
  end

  // History ring: one write on an interpolating accept, one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[head_r + HIST_AW'(1)] <= in_ch.sample_in;
    end
    rd_data_r <= hist_mem[rd_addr];
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_out  = out_sample_r;
  assign out_ch.has_sample  = out_has_r;
  assign out_ch.end_of_clip = out_eoc_r;
  assign out_ch.run_last    = out_last_r;

  // Interpolation never reaches outside the history ring
  a_hist_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADDR_A) |-> ((l_cur <= L_HIST) && (l_cur != '0)))
    else $error("interpolation position outside history ring");

  // A bare marker closes the clip and the transaction
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_r) |-> (out_eoc_r && out_last_r))
    else $error("marker result without end flags");

  // The clip only ends on the last result of a transaction
  a_eoc_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eoc_r) |-> out_last_r)
    else $error("end of clip before last result");

  // An emitted result leaves the sequencer in a fetch or idle step
  a_emit_next: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && out_free) |=> ((state_r == S_ADDR_A) || (state_r == S_IDLE)))
    else $error("sequencer lost after emit");

endmodule

`default_nettype wire
